@@ rtl/assert_macros.svh @@
// assertion macros used by gmm_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define GMM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GMM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/gmm_pkg.sv @@
// shared types and constants of the gap method merge unit
`timescale 1ns / 1ps

package gmm_pkg;

    localparam int WORD_W   = 32;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COUNT = 2'd1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS,
        ST_RD_A,
        ST_RD_B,
        ST_CMP,
        ST_WR_A,
        ST_WR_B,
        ST_GAP,
        ST_OUT_RD,
        ST_OUT_CAP
    } state_t;

    typedef struct packed {
        logic load_we;
        logic rd_a;
        logic rd_b;
        logic cap_b;
        logic wr_a;
        logic wr_b;
        logic pair_inc;
        logic gap_next;
        logic out_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic load_last;
        logic pass_more;
        logic gap_one;
        logic swap;
        logic out_free;
        logic out_last;
    } status_t;

endpackage

@@ rtl/gmm_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module gmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/gmm_datapath.sv @@
// datapath: count registers, word store, gap and pair counters, compare and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmm_datapath #(
    parameter int MAX_LIST = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  gmm_pkg::cnt_t                 cfg_data,
    input  gmm_pkg::word_t                in_word,
    input  gmm_pkg::cmd_t                 cmd,
    output gmm_pkg::status_t              status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output gmm_pkg::word_t                m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int DEPTH = 2 * MAX_LIST;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);

    gmm_pkg::cnt_t first_reg, second_reg;
    logic [TW-1:0] load_count_reg, pair_reg, gap_reg, out_idx_reg;
    logic [TW-1:0] n_sat, m_sat, total;
    logic [TW:0]   pair_gap, gap_up;
    gmm_pkg::word_t a_reg, b_reg;
    gmm_pkg::word_t wdata, rdata;
    logic [AW-1:0] waddr, raddr;
    logic          we;
    logic          out_valid_reg;
    logic          cfg_hit;

    // counts above the list limit saturate
    assign n_sat = (first_reg > gmm_pkg::CNT_W'(MAX_LIST)) ? TW'(MAX_LIST)
                                                           : TW'(first_reg);
    assign m_sat = (second_reg > gmm_pkg::CNT_W'(MAX_LIST)) ? TW'(MAX_LIST)
                                                            : TW'(second_reg);
    assign total    = n_sat + m_sat;
    assign pair_gap = {1'b0, pair_reg} + {1'b0, gap_reg};
    assign gap_up   = {1'b0, gap_reg} + (TW+1)'(1);

    assign cfg_hit = cfg_we && (cfg_index == gmm_pkg::REG_FIRST_COUNT ||
                                cfg_index == gmm_pkg::REG_SECOND_COUNT);

    always_comb
    begin
        status.total_zero = (total == '0);
        status.load_last  = ((load_count_reg + TW'(1)) == total);
        status.pass_more  = (pair_gap < {1'b0, total});
        status.gap_one    = (gap_reg == TW'(1));
        status.swap       = (a_reg > rdata);
        status.out_free   = !out_valid_reg || m_tready;
        status.out_last   = ((out_idx_reg + TW'(1)) == total);
    end

    // store port selection
    always_comb
    begin
        we    = cmd.load_we || cmd.wr_a || cmd.wr_b;
        waddr = load_count_reg[AW-1:0];
        wdata = in_word;
        if (cmd.wr_a)
        begin
            waddr = pair_reg[AW-1:0];
            wdata = b_reg;
        end
        else if (cmd.wr_b)
        begin
            waddr = pair_gap[AW-1:0];
            wdata = a_reg;
        end
        if (cmd.rd_a)
        begin
            raddr = pair_reg[AW-1:0];
        end
        else if (cmd.rd_b)
        begin
            raddr = pair_gap[AW-1:0];
        end
        else if (cmd.out_rd)
        begin
            raddr = out_idx_reg[AW-1:0];
        end
        else
        begin
            raddr = pair_reg[AW-1:0];
        end
    end

    gmm_ram #(
        .WIDTH (gmm_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= '0;
            second_reg     <= '0;
            load_count_reg <= '0;
            pair_reg       <= '0;
            gap_reg        <= '0;
            out_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == gmm_pkg::REG_FIRST_COUNT)
            begin
                first_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == gmm_pkg::REG_SECOND_COUNT)
            begin
                second_reg <= cfg_data;
            end

            if (cfg_hit)
            begin
                load_count_reg <= '0;
            end
            else if (cmd.load_we)
            begin
                if (status.load_last)
                begin
                    load_count_reg <= '0;
                end
                else
                begin
                    load_count_reg <= load_count_reg + TW'(1);
                end
            end

            // last word loaded: first gap is ceil(total/2)
            if (cmd.load_we && status.load_last)
            begin
                gap_reg     <= TW'(({1'b0, total} + (TW+1)'(1)) >> 1);
                pair_reg    <= '0;
                out_idx_reg <= '0;
            end
            else if (cmd.gap_next)
            begin
                gap_reg  <= TW'(gap_up >> 1);
                pair_reg <= '0;
            end
            else if (cmd.pair_inc)
            begin
                pair_reg <= pair_reg + TW'(1);
            end

            if (cmd.out_load)
            begin
                out_idx_reg <= out_idx_reg + TW'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
        begin
            a_reg <= rdata;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rdata;
        end
        if (cmd.out_load)
        begin
            m_tdata <= rdata;
            m_tuser <= (out_idx_reg >= n_sat);
            m_tlast <= status.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;

    `GMM_ASSERT_ALWAYS(a_load_bound, status.total_zero || load_count_reg < total, "load overrun")
    `GMM_ASSERT_IMPL(a_rd_b_bound, cmd.rd_b, status.pass_more, "pair partner outside run")
    `GMM_ASSERT_IMPL(a_out_slot, cmd.out_load, !out_valid_reg, "output register overwritten")

endmodule

@@ rtl/gmm_ctrl.sv @@
// controller: sequences loading, gap passes and the output run
`timescale 1ns / 1ps

module gmm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gmm_pkg::status_t  status,
    output gmm_pkg::cmd_t     cmd
);

    gmm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmm_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmm_pkg::ST_LOAD:
            begin
                if (s_tvalid && !status.total_zero && status.load_last)
                begin
                    state_next = gmm_pkg::ST_PASS;
                end
            end
            gmm_pkg::ST_PASS:
            begin
                state_next = status.pass_more ? gmm_pkg::ST_RD_A : gmm_pkg::ST_GAP;
            end
            gmm_pkg::ST_RD_A:
            begin
                state_next = gmm_pkg::ST_RD_B;
            end
            gmm_pkg::ST_RD_B:
            begin
                state_next = gmm_pkg::ST_CMP;
            end
            gmm_pkg::ST_CMP:
            begin
                state_next = status.swap ? gmm_pkg::ST_WR_A : gmm_pkg::ST_PASS;
            end
            gmm_pkg::ST_WR_A:
            begin
                state_next = gmm_pkg::ST_WR_B;
            end
            gmm_pkg::ST_WR_B:
            begin
                state_next = gmm_pkg::ST_PASS;
            end
            gmm_pkg::ST_GAP:
            begin
                state_next = status.gap_one ? gmm_pkg::ST_OUT_RD : gmm_pkg::ST_PASS;
            end
            gmm_pkg::ST_OUT_RD:
            begin
                if (status.out_free)
                begin
                    state_next = gmm_pkg::ST_OUT_CAP;
                end
            end
            gmm_pkg::ST_OUT_CAP:
            begin
                state_next = status.out_last ? gmm_pkg::ST_LOAD : gmm_pkg::ST_OUT_RD;
            end
            default:
            begin
                state_next = gmm_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            gmm_pkg::ST_LOAD:
            begin
                s_tready    = 1'b1;
                // with an empty run the item is dropped
                cmd.load_we = s_tvalid && !status.total_zero;
            end
            gmm_pkg::ST_RD_A:
            begin
                cmd.rd_a = 1'b1;
            end
            gmm_pkg::ST_RD_B:
            begin
                cmd.rd_b = 1'b1;
            end
            gmm_pkg::ST_CMP:
            begin
                cmd.cap_b    = 1'b1;
                cmd.pair_inc = !status.swap;
            end
            gmm_pkg::ST_WR_A:
            begin
                cmd.wr_a = 1'b1;
            end
            gmm_pkg::ST_WR_B:
            begin
                cmd.wr_b     = 1'b1;
                cmd.pair_inc = 1'b1;
            end
            gmm_pkg::ST_GAP:
            begin
                cmd.gap_next = !status.gap_one;
            end
            gmm_pkg::ST_OUT_RD:
            begin
                cmd.out_rd = status.out_free;
            end
            gmm_pkg::ST_OUT_CAP:
            begin
                cmd.out_load = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/gap_method_merge_unit.sv @@
// Gap method merge unit: loads first_count then second_count signed words (each count saturated
// to MAX_LIST), merges the two sorted lists in place in a single-port-read word store, then
// streams the merged run with tlast on the final word. Loading takes one item per cycle. The
// merge runs ceil(log2(total)) passes, a single pass when total is 1; each pair in a pass is
// read one word at a time through the single read port, compared, and, when swapped, written
// back one word at a time through the single write port; each pass ends with the end check and
// the gap update. Each output word is read from the store and then loaded into the output
// register, which holds it while the receiver stalls. Nothing is accepted from the last loaded
// item until the last merged word has entered the output register.
`timescale 1ns / 1ps

module gap_method_merge_unit #(
    parameter int MAX_LIST = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmm_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // word_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // word_out
    output logic                          m_tuser,   // in_second
    output logic                          m_tlast    // last_word
);

    gmm_pkg::cmd_t    cmd;
    gmm_pkg::status_t status;
    gmm_pkg::word_t   out_word;

    gmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gmm_datapath #(
        .MAX_LIST (MAX_LIST)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (gmm_pkg::word_t'(s_tdata)),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (out_word),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = out_word;

endmodule

@@ tb/gmm_checker.sv @@
// checker for the gap method merge unit: predicts the merged runs and compares the output items
`timescale 1ns / 1ps

module gmm_checker #(
    parameter int MAX_LIST = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmm_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // word_in
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [31:0]                   m_tdata,   // word_out
    input  logic                          m_tuser,   // in_second
    input  logic                          m_tlast,   // last_word
    output int                            fail_count,
    output int                            pending
);

    localparam int STORE_DEPTH = 64;

    typedef struct packed {
        gmm_pkg::word_t word;
        logic           second;
        logic           last;
    } merged_t;

    merged_t        merged_q[$];
    gmm_pkg::word_t word_store[STORE_DEPTH];
    gmm_pkg::cnt_t  first_len_reg;
    gmm_pkg::cnt_t  second_len_reg;
    int unsigned    load_cnt;
    int unsigned    first_len;
    int unsigned    total_len;
    merged_t        exp_item;

    function automatic int unsigned clip_len(input gmm_pkg::cnt_t c);
        return (c > MAX_LIST) ? MAX_LIST : c;
    endfunction

    // gap passes over the loaded words, then queue the whole run in order
    task automatic merge_loaded(input int unsigned total, input int unsigned n);
        int unsigned    gap;
        int unsigned    i;
        gmm_pkg::word_t tmp;
        merged_t        e;
        gap = (total + 1) / 2;
        while (gap > 0)
        begin
            for (i = 0; i + gap < total; i++)
            begin
                if (word_store[i] > word_store[i + gap])
                begin
                    tmp                  = word_store[i];
                    word_store[i]        = word_store[i + gap];
                    word_store[i + gap]  = tmp;
                end
            end
            gap = (gap == 1) ? 0 : (gap + 1) / 2;
        end
        for (i = 0; i < total; i++)
        begin
            e.word   = word_store[i];
            e.second = (i >= n);
            e.last   = (i + 1 == total);
            merged_q.push_back(e);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merged_q.delete();
            load_cnt       = 0;
            first_len_reg  = '0;
            second_len_reg = '0;
            fail_count     = 0;
            pending        = 0;
        end
        else
        begin
            // a count write restarts loading, other indexes do nothing
            if (cfg_we)
            begin
                if (cfg_index == gmm_pkg::REG_FIRST_COUNT)
                begin
                    first_len_reg = cfg_data;
                    load_cnt      = 0;
                end
                else if (cfg_index == gmm_pkg::REG_SECOND_COUNT)
                begin
                    second_len_reg = cfg_data;
                    load_cnt       = 0;
                end
            end

            if (s_tvalid && s_tready)
            begin
                first_len = clip_len(first_len_reg);
                total_len = first_len + clip_len(second_len_reg);
                if (total_len != 0)
                begin
                    word_store[load_cnt % STORE_DEPTH] = s_tdata;
                    load_cnt = (load_cnt + 1) % 128;
                    if (load_cnt >= total_len)
                    begin
                        merge_loaded(total_len, first_len);
                        load_cnt = 0;
                    end
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (merged_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected output item word=%0d user=%0b last=%0b",
                                 $realtime, $signed(m_tdata), m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_item = merged_q.pop_front();
                    if (m_tdata !== exp_item.word || m_tuser !== exp_item.second ||
                        m_tlast !== exp_item.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch expected word=%0d user=%0b last=%0b",
                                     $realtime, exp_item.word, exp_item.second,
                                     exp_item.last);
                            $display("%0t:          got word=%0d user=%0b last=%0b",
                                     $realtime, $signed(m_tdata), m_tuser, m_tlast);
                        end
                        fail_count++;
                    end
                end
            end

            pending = merged_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// top of the gap method merge unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_LIST      = 32;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 500;

    // indexes past the two count registers
    localparam logic [gmm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [gmm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [gmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gmm_pkg::CNT_W-1:0]     cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata   = '0;   // word_in
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [31:0]                   m_tdata;          // word_out
    logic                          m_tuser;          // in_second
    logic                          m_tlast;          // last_word

    int             fail_count;
    int             pending;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    bit             hold_req      = 1'b0;
    bit             hold_seen     = 1'b0;
    int             hold_left     = 0;
    int             items_sent    = 0;
    gmm_pkg::cnt_t  cur_first     = '0;
    gmm_pkg::cnt_t  cur_second    = '0;
    gmm_pkg::word_t run_buf[64];

    gap_method_merge_unit #(
        .MAX_LIST (MAX_LIST)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    gmm_checker #(
        .MAX_LIST (MAX_LIST)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // receiver: random stalls, plus a long hold-off when asked for
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned clip_len(input gmm_pkg::cnt_t c);
        return (c > MAX_LIST) ? MAX_LIST : c;
    endfunction

    function automatic gmm_pkg::word_t pick_word();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1, 2, 3:
            begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gmm_pkg::CFG_IDX_W-1:0] idx,
                             input gmm_pkg::cnt_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_counts(input gmm_pkg::cnt_t f, input gmm_pkg::cnt_t s);
        wait_idle();
        write_reg(gmm_pkg::REG_FIRST_COUNT, f);
        write_reg(gmm_pkg::REG_SECOND_COUNT, s);
        cur_first  = f;
        cur_second = s;
    endtask

    task automatic send_word(input gmm_pkg::word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic sort_range(input int lo, input int hi);
        int             i;
        int             j;
        gmm_pkg::word_t key;
        for (i = lo + 1; i < hi; i++)
        begin
            key = run_buf[i];
            j   = i - 1;
            while (j >= lo && run_buf[j] > key)
            begin
                run_buf[j + 1] = run_buf[j];
                j = j - 1;
            end
            run_buf[j + 1] = key;
        end
    endtask

    // one run of two lists, sorted unless asked for noise; only the first limit words go out
    task automatic send_run(input int n, input int m, input bit sorted, input int limit);
        int i;
        for (i = 0; i < n + m; i++)
            run_buf[i] = pick_word();
        if (sorted)
        begin
            sort_range(0, n);
            sort_range(n, n + m);
        end
        for (i = 0; i < limit; i++)
            send_word(run_buf[i]);
        items_sent += limit;
    endtask

    initial
    begin
        int            run_no;
        int            n;
        int            m;
        int            lim;
        int            phase;
        bit            keep_cfg;
        bit            new_cfg;
        gmm_pkg::cnt_t f;
        gmm_pkg::cnt_t s;

        run_no   = 0;
        keep_cfg = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both counts zero after reset: items are swallowed
        send_word(32'sd17);
        send_word(-32'sd5);

        set_counts(6'd1, 6'd0);
        send_word(32'sh7FFF_FFFF);

        set_counts(6'd0, 6'd1);
        send_word(32'sh8000_0000);

        set_counts(6'd2, 6'd3);
        send_word(32'sh8000_0000);
        send_word(32'sd5);
        send_word(-32'sd7);
        send_word(32'sd0);
        send_word(32'sh7FFF_FFFF);

        // count write part way through loading drops what was loaded
        set_counts(6'd3, 6'd2);
        send_word(32'sd11);
        send_word(-32'sd4);
        set_counts(6'd3, 6'd2);
        send_word(32'sd1);
        send_word(32'sd2);
        send_word(32'sd3);
        send_word(-32'sd1);
        send_word(32'sd4);

        // spare indexes leave loading alone; unsorted first list
        set_counts(6'd2, 6'd2);
        send_word(32'sd9);
        wait_idle();
        write_reg(REG_SPARE_A, 6'h3F);
        write_reg(REG_SPARE_B, 6'h2A);
        send_word(-32'sd3);
        send_word(32'sd4);
        send_word(32'sd4);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            phase = (items_sent * 4) / RANDOM_ITEMS;
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 54;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 54;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase

            new_cfg = 1'b1;
            if (run_no == 4)
            begin
                f = 6'd6;
                s = 6'd5;
            end
            else if (run_no == 10)
            begin
                f = 6'd63;
                s = 6'd40;
            end
            else if (run_no == 20)
            begin
                f = 6'd32;
                s = 6'd0;
            end
            else if (run_no == 30)
            begin
                f = 6'd0;
                s = 6'd33;
            end
            else if (run_no == 0 || (!keep_cfg && $urandom_range(0, 2) == 0))
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        f = 6'd0;
                        s = gmm_pkg::cnt_t'($urandom_range(1, 8));
                    end
                    1:
                    begin
                        f = gmm_pkg::cnt_t'($urandom_range(1, 8));
                        s = 6'd0;
                    end
                    2:
                    begin
                        f = 6'd0;
                        s = 6'd0;
                    end
                    default:
                    begin
                        f = gmm_pkg::cnt_t'($urandom_range(1, 8));
                        s = gmm_pkg::cnt_t'($urandom_range(1, 8));
                    end
                endcase
            end
            else
                new_cfg = 1'b0;

            if (new_cfg)
                set_counts(f, s);
            keep_cfg = 1'b0;

            // long hold-off on the output while two runs are offered back to back
            if (run_no == 4)
            begin
                hold_req = ~hold_req;
                keep_cfg = 1'b1;
            end

            n = clip_len(cur_first);
            m = clip_len(cur_second);
            if (n + m == 0)
            begin
                repeat (3) send_word(pick_word());
                items_sent += 3;
            end
            else if (n + m > 1 && $urandom_range(0, 19) == 0)
            begin
                lim = $urandom_range(1, n + m - 1);
                send_run(n, m, 1'b1, lim);
                set_counts(cur_first, cur_second);
            end
            else
                send_run(n, m, ($urandom_range(0, 99) >= 15), n + m);
            run_no++;
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ gap_method_merge_unit.f @@
+incdir+rtl
rtl/gmm_pkg.sv
rtl/gmm_ram.sv
rtl/gmm_datapath.sv
rtl/gmm_ctrl.sv
rtl/gap_method_merge_unit.sv
tb/gmm_checker.sv
tb/tb_top.sv
